FILE: sv/jvbl_pkg.sv
// Shared types, constants and helper functions of the joint velocity bound limiter.
package jvbl_pkg;

  // Internal velocity width: wide enough for the previous velocity plus one full step.
  localparam int VW = 38;
  localparam int SQRT_STAGES = 32;
  localparam int RATE_W = 47;

  typedef logic signed [VW-1:0] vel_t;

  localparam vel_t MAX_Q = vel_t'(64'sd2147483647);
  localparam vel_t MIN_Q = -vel_t'(64'sd2147483648);

  typedef struct packed {
    logic [24:0] step_time;
    logic [30:0] step_rate;
    logic [30:0] crawl_speed;
    logic [15:0] tolerance;
  } cfg_t;

  typedef struct packed {
    vel_t              ub0;
    vel_t              lb0;
    vel_t              brk;
    logic [30:0]       half;
    logic [RATE_W-1:0] rate_hi;
    logic [RATE_W-1:0] rate_lo;
    logic              pos_hi;
    logic              pos_lo;
    logic              ovf_hi;
    logic              ovf_lo;
    logic              en_hi;
    logic              en_lo;
    logic              last;
  } side_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  function automatic vel_t ext_u32(logic [31:0] x);
    return vel_t'({{(VW-32){1'b0}}, x});
  endfunction

  function automatic vel_t vel_min(vel_t a, vel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic vel_t vel_max(vel_t a, vel_t b);
    return (a > b) ? a : b;
  endfunction

  // One digit of a restoring square root: brings down two radicand bits.
  function automatic sq_t sqrt_step(logic [33:0] rem, logic [31:0] root, logic [1:0] pair);
    logic [35:0] acc;
    logic [35:0] trial;
    sq_t         r;
    acc   = {rem, pair};
    trial = {2'b00, root, 2'b01};
    if (acc >= trial) begin
      r.rem  = 34'(acc - trial);
      r.root = {root[30:0], 1'b1};
    end else begin
      r.rem  = acc[33:0];
      r.root = {root[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: sv/jvbl_front.sv
// Front stages: velocity steps, acceleration box, crawl clamp and braking radicands.
module jvbl_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  jvbl_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  input  logic signed [31:0]    prev_velocity,
  input  logic signed [31:0]    position,
  input  logic signed [31:0]    upper_limit,
  input  logic signed [31:0]    lower_limit,
  input  logic                  upper_enabled,
  input  logic                  lower_enabled,
  input  logic                  hold_joint,
  input  logic                  crawl_active,
  input  logic [30:0]           speed_limit,
  input  logic [30:0]           accel_limit,
  input  logic [30:0]           decel_limit,
  input  logic                  last_joint,
  output logic                  out_valid,
  output logic [63:0]           rad_hi,
  output logic [63:0]           rad_lo,
  output jvbl_pkg::side_t       side
);
  import jvbl_pkg::*;

  // Stage 1
  logic               v1;
  logic signed [31:0] vp1;
  logic [55:0]        acc_p1;
  logic [55:0]        dec_p1;
  logic signed [32:0] dh1;
  logic signed [32:0] dl1;
  logic [30:0]        spd1;
  logic [30:0]        dec1;
  logic               hold1;
  logic               crawl1;
  logic               en_hi1;
  logic               en_lo1;
  logic               last1;

  // Stage 2
  logic        v2;
  logic [61:0] hh2;
  logic [62:0] lin_hi2;
  logic [62:0] lin_lo2;
  logic [62:0] rate_hi2;
  logic [62:0] rate_lo2;
  vel_t        ub2;
  vel_t        lb2;
  vel_t        brk2;
  logic [30:0] half2;
  logic        pos_hi2;
  logic        pos_lo2;
  logic        en_hi2;
  logic        en_lo2;
  logic        last2;

  // Stage 2 combinational
  logic [31:0] acc_step;
  logic [31:0] dec_step;
  logic [30:0] half;
  vel_t        vpx;
  vel_t        acc_v;
  vel_t        dec_v;
  vel_t        up_v;
  vel_t        dn_v;
  vel_t        spd_v;
  vel_t        ub_box;
  vel_t        lb_box;
  vel_t        vc;
  vel_t        ub_c;
  vel_t        lb_c;
  vel_t        mag;
  vel_t        s;
  vel_t        brk;
  logic        pos_hi;
  logic        pos_lo;
  logic [31:0] d_hi;
  logic [31:0] d_lo;

  // Stage 3 combinational
  logic [64:0] sum_hi;
  logic [64:0] sum_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vp1    <= prev_velocity;
      acc_p1 <= 56'(accel_limit) * 56'(cfg.step_time);
      dec_p1 <= 56'(decel_limit) * 56'(cfg.step_time);
      dh1    <= {upper_limit[31], upper_limit} - {position[31], position};
      dl1    <= {position[31], position} - {lower_limit[31], lower_limit};
      spd1   <= speed_limit;
      dec1   <= decel_limit;
      hold1  <= hold_joint;
      crawl1 <= crawl_active && (cfg.crawl_speed != '0);
      en_hi1 <= upper_enabled;
      en_lo1 <= lower_enabled;
      last1  <= last_joint;
    end
  end

  always_comb begin
    acc_step = acc_p1[55:24];
    dec_step = dec_p1[55:24];
    half     = dec_p1[55:25];
    vpx      = vel_t'(vp1);
    acc_v    = ext_u32(acc_step);
    dec_v    = ext_u32(dec_step);
    up_v     = vp1[31] ? dec_v : acc_v;
    dn_v     = (!vp1[31] && (vp1 != '0)) ? dec_v : acc_v;
    spd_v    = ext_u32({1'b0, spd1});
    ub_box   = vel_min(spd_v, vpx + up_v);
    lb_box   = vel_max(-spd_v, vpx - dn_v);
    vc       = hold1 ? '0 : ext_u32({1'b0, cfg.crawl_speed});
    if (hold1 || crawl1) begin
      ub_c = vel_min(ub_box, vel_max(vc, vpx - dec_v));
      lb_c = vel_max(lb_box, vel_min(-vc, vpx + dec_v));
    end else begin
      ub_c = ub_box;
      lb_c = lb_box;
    end
    // Brake velocity used when the bounds conflict: one decel step toward zero.
    mag    = vp1[31] ? -vpx : vpx;
    s      = vel_min(mag, dec_v);
    brk    = vp1[31] ? vpx + s : vpx - s;
    pos_hi = dh1 > 33'sd0;
    pos_lo = dl1 > 33'sd0;
    d_hi   = pos_hi ? dh1[31:0] : '0;
    d_lo   = pos_lo ? dl1[31:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hh2      <= 62'(half) * 62'(half);
      lin_hi2  <= 63'(dec1) * 63'(d_hi);
      lin_lo2  <= 63'(dec1) * 63'(d_lo);
      rate_hi2 <= 63'(d_hi) * 63'(cfg.step_rate);
      rate_lo2 <= 63'(d_lo) * 63'(cfg.step_rate);
      ub2      <= ub_c;
      lb2      <= lb_c;
      brk2     <= brk;
      half2    <= half;
      pos_hi2  <= pos_hi;
      pos_lo2  <= pos_lo;
      en_hi2   <= en_hi1;
      en_lo2   <= en_lo1;
      last2    <= last1;
    end
  end

  assign sum_hi = 65'(hh2) + {1'b0, lin_hi2, 1'b0};
  assign sum_lo = 65'(hh2) + {1'b0, lin_lo2, 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      rad_hi       <= sum_hi[63:0];
      rad_lo       <= sum_lo[63:0];
      side.ub0     <= ub2;
      side.lb0     <= lb2;
      side.brk     <= brk2;
      side.half    <= half2;
      side.rate_hi <= rate_hi2[62:16];
      side.rate_lo <= rate_lo2[62:16];
      side.pos_hi  <= pos_hi2;
      side.pos_lo  <= pos_lo2;
      side.ovf_hi  <= sum_hi[64];
      side.ovf_lo  <= sum_lo[64];
      side.en_hi   <= en_hi2;
      side.en_lo   <= en_lo2;
      side.last    <= last2;
    end
  end

endmodule

FILE: sv/jvbl_sqrt.sv
// Two-lane pipelined integer square root, one root bit per stage.
module jvbl_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [63:0]     rad_hi,
  input  logic [63:0]     rad_lo,
  input  jvbl_pkg::side_t side_in,
  output logic            out_valid,
  output logic [31:0]     root_hi,
  output logic [31:0]     root_lo,
  output jvbl_pkg::side_t side_out
);
  import jvbl_pkg::*;

  localparam int NS = SQRT_STAGES;

  logic        v   [NS];
  logic [63:0] xh  [NS];
  logic [63:0] xl  [NS];
  logic [33:0] rh  [NS];
  logic [33:0] rl  [NS];
  logic [31:0] qh  [NS];
  logic [31:0] ql  [NS];
  side_t       sd  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic        pv;
    logic [63:0] pxh;
    logic [63:0] pxl;
    logic [33:0] prh;
    logic [33:0] prl;
    logic [31:0] pqh;
    logic [31:0] pql;
    side_t       psd;
    sq_t         nh;
    sq_t         nl;

    if (k == 0) begin : g_first
      assign pv  = in_valid;
      assign pxh = rad_hi;
      assign pxl = rad_lo;
      assign prh = '0;
      assign prl = '0;
      assign pqh = '0;
      assign pql = '0;
      assign psd = side_in;
    end else begin : g_next
      assign pv  = v[k-1];
      assign pxh = xh[k-1];
      assign pxl = xl[k-1];
      assign prh = rh[k-1];
      assign prl = rl[k-1];
      assign pqh = qh[k-1];
      assign pql = ql[k-1];
      assign psd = sd[k-1];
    end

    assign nh = sqrt_step(prh, pqh, pxh[63:62]);
    assign nl = sqrt_step(prl, pql, pxl[63:62]);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xh[k] <= {pxh[61:0], 2'b00};
        xl[k] <= {pxl[61:0], 2'b00};
        rh[k] <= nh.rem;
        rl[k] <= nl.rem;
        qh[k] <= nh.root;
        ql[k] <= nl.root;
        sd[k] <= psd;
      end
    end
  end

  assign out_valid = v[NS-1];
  assign root_hi   = qh[NS-1];
  assign root_lo   = ql[NS-1];
  assign side_out  = sd[NS-1];

endmodule

FILE: sv/jvbl_back.sv
// Back stages: braking bounds, bound combination, crossing resolution and output skid.
module jvbl_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        tolerance,
  input  logic               in_valid,
  input  logic [31:0]        root_hi,
  input  logic [31:0]        root_lo,
  input  jvbl_pkg::side_t    side,
  output logic               en,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] lower_bound,
  output logic signed [31:0] upper_bound,
  output logic               brake_flag,
  output logic               cycle_end
);
  import jvbl_pkg::*;

  // Braking bound toward one limit: min of distance over dt and root minus half step.
  function automatic logic [30:0] lim_bound(logic [31:0] root, logic [30:0] half,
                                            logic ovf, logic pos,
                                            logic [RATE_W-1:0] rate);
    logic [32:0] diff;
    logic [30:0] brake;
    logic [30:0] res;
    diff  = {1'b0, root} - {2'b00, half};
    brake = (ovf || (diff > 33'h07FFFFFFF)) ? 31'h7FFFFFFF : diff[30:0];
    if (!pos) begin
      res = '0;
    end else if (rate < RATE_W'(brake)) begin
      res = rate[30:0];
    end else begin
      res = brake;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(vel_t x);
    vel_t c;
    c = vel_min(vel_max(x, MIN_Q), MAX_Q);
    return c[31:0];
  endfunction

  logic        v1;
  logic [30:0] lim_hi1;
  logic [30:0] lim_lo1;
  side_t       sd1;

  logic        v2;
  vel_t        ub2;
  vel_t        lb2;
  vel_t        brk2;
  logic        last2;

  logic        skid;
  logic signed [31:0] sk_lb;
  logic signed [31:0] sk_ub;
  logic        sk_conf;
  logic        sk_last;

  vel_t        ub_n;
  vel_t        lb_n;
  vel_t        diff;
  vel_t        res_lb;
  vel_t        res_ub;
  logic        res_conf;
  logic signed [31:0] new_lb;
  logic signed [31:0] new_ub;
  logic        out_free;

  assign en = !skid;
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lim_hi1 <= lim_bound(root_hi, side.half, side.ovf_hi, side.pos_hi, side.rate_hi);
      lim_lo1 <= lim_bound(root_lo, side.half, side.ovf_lo, side.pos_lo, side.rate_lo);
      sd1     <= side;
    end
  end

  always_comb begin
    ub_n = sd1.en_hi ? vel_min(sd1.ub0, ext_u32({1'b0, lim_hi1})) : sd1.ub0;
    lb_n = sd1.en_lo ? vel_max(sd1.lb0, -ext_u32({1'b0, lim_lo1})) : sd1.lb0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ub2   <= ub_n;
      lb2   <= lb_n;
      brk2  <= sd1.brk;
      last2 <= sd1.last;
    end
  end

  always_comb begin
    diff     = lb2 - ub2;
    res_lb   = lb2;
    res_ub   = ub2;
    res_conf = 1'b0;
    if (lb2 > ub2) begin
      if (diff <= ext_u32({16'b0, tolerance})) begin
        res_lb = ub2;
      end else begin
        res_lb   = brk2;
        res_ub   = brk2;
        res_conf = 1'b1;
      end
    end
    new_lb = sat32(res_lb);
    new_ub = sat32(res_ub);
  end

  // The skid slot takes the request that leaves the pipeline while the output is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid         <= 1'b0;
    end else if (out_free) begin
      if (skid) begin
        result_valid <= 1'b1;
        skid         <= 1'b0;
      end else begin
        result_valid <= v2;
      end
    end else if (v2) begin
      skid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid) begin
        lower_bound <= sk_lb;
        upper_bound <= sk_ub;
        brake_flag  <= sk_conf;
        cycle_end   <= sk_last;
      end else begin
        lower_bound <= new_lb;
        upper_bound <= new_ub;
        brake_flag  <= res_conf;
        cycle_end   <= last2;
      end
    end else if (!skid) begin
      sk_lb   <= new_lb;
      sk_ub   <= new_ub;
      sk_conf <= res_conf;
      sk_last <= last2;
    end
  end

endmodule

FILE: sv/joint_velocity_bound_limiter_unit.sv
// Top level of the joint velocity bound limiter: configuration registers and pipeline.
// Pipeline from an accepted request to its result on the output register
// (3 front stages, 32 square root stages, 2 back stages, 1 output register).
// Throughput: one joint per cycle while not stalled; the 32-stage square root pipeline sets the latency.
// A held output parks one result in a skid slot before the input stalls.
// Reset clears all valid bits and restores the configuration registers to defaults.
module joint_velocity_bound_limiter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [31:0] prev_velocity,
  input  logic signed [31:0] position,
  input  logic signed [31:0] upper_limit,
  input  logic signed [31:0] lower_limit,
  input  logic               upper_enabled,
  input  logic               lower_enabled,
  input  logic               hold_joint,
  input  logic               crawl_active,
  input  logic [30:0]        speed_limit,
  input  logic [30:0]        accel_limit,
  input  logic [30:0]        decel_limit,
  input  logic               last_joint,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] lower_bound,
  output logic signed [31:0] upper_bound,
  output logic               brake_flag,
  output logic               cycle_end
);
  import jvbl_pkg::*;

  localparam logic [3:0] REG_STEP_TIME = 4'd0;
  localparam logic [3:0] REG_STEP_RATE = 4'd1;
  localparam logic [3:0] REG_CRAWL     = 4'd2;
  localparam logic [3:0] REG_TOL       = 4'd3;

  cfg_t        cfg;
  logic        en;
  logic        f_valid;
  logic [63:0] f_rad_hi;
  logic [63:0] f_rad_lo;
  side_t       f_side;
  logic        s_valid;
  logic [31:0] s_root_hi;
  logic [31:0] s_root_lo;
  side_t       s_side;

  assign cfg_ready  = 1'b1;
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_time   <= 25'd167772;
      cfg.step_rate   <= 31'd6553600;
      cfg.crawl_speed <= '0;
      cfg.tolerance   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP_TIME: cfg.step_time   <= cfg_data[24:0];
        REG_STEP_RATE: cfg.step_rate   <= cfg_data[30:0];
        REG_CRAWL:     cfg.crawl_speed <= cfg_data[30:0];
        REG_TOL:       cfg.tolerance   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  jvbl_front u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .cfg           (cfg),
    .in_valid      (item_valid),
    .prev_velocity (prev_velocity),
    .position      (position),
    .upper_limit   (upper_limit),
    .lower_limit   (lower_limit),
    .upper_enabled (upper_enabled),
    .lower_enabled (lower_enabled),
    .hold_joint    (hold_joint),
    .crawl_active  (crawl_active),
    .speed_limit   (speed_limit),
    .accel_limit   (accel_limit),
    .decel_limit   (decel_limit),
    .last_joint    (last_joint),
    .out_valid     (f_valid),
    .rad_hi        (f_rad_hi),
    .rad_lo        (f_rad_lo),
    .side          (f_side)
  );

  jvbl_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .rad_hi    (f_rad_hi),
    .rad_lo    (f_rad_lo),
    .side_in   (f_side),
    .out_valid (s_valid),
    .root_hi   (s_root_hi),
    .root_lo   (s_root_lo),
    .side_out  (s_side)
  );

  jvbl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .tolerance    (cfg.tolerance),
    .in_valid     (s_valid),
    .root_hi      (s_root_hi),
    .root_lo      (s_root_lo),
    .side         (s_side),
    .en           (en),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .lower_bound  (lower_bound),
    .upper_bound  (upper_bound),
    .brake_flag   (brake_flag),
    .cycle_end    (cycle_end)
  );

endmodule
